/* hdl/vfd_pkg.sv */
// Shared constants, types and the character segment table for the VFD frame builder.
package vfd_pkg;

  localparam int unsigned DigitCountDefault = 8;
  localparam int unsigned FrameBitsDefault  = 20;
  localparam int unsigned MaxDigits         = 8;
  localparam int unsigned PosW              = 3;
  localparam int unsigned CharW             = 8;
  localparam int unsigned FrameW            = 20;
  localparam int unsigned FrameIdxW         = $clog2(FrameW);
  localparam int unsigned GridTopBit        = 15;
  localparam int unsigned DotBit            = 7;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_SCAN  = 1'b1
  } vfd_op_t;

  typedef logic [PosW-1:0]  vfd_pos_t;
  typedef logic [CharW-1:0] vfd_char_t;

  // Segment pattern as {high nibble, low nibble}; unmapped codes are blank.
  function automatic logic [7:0] seg_lookup(input vfd_char_t c);
    logic [7:0] seg;
    unique case (c)
      8'h30:   seg = 8'h7E; // 0
      8'h31:   seg = 8'h30; // 1
      8'h32:   seg = 8'h6D; // 2
      8'h33:   seg = 8'h79; // 3
      8'h34:   seg = 8'h33; // 4
      8'h35:   seg = 8'h5B; // 5
      8'h36:   seg = 8'h5F; // 6
      8'h37:   seg = 8'h70; // 7
      8'h38:   seg = 8'h7F; // 8
      8'h39:   seg = 8'h7B; // 9
      8'h41:   seg = 8'h77; // A
      8'h42:   seg = 8'h1F; // B
      8'h63:   seg = 8'h4E; // c
      8'h43:   seg = 8'h4E; // C
      8'h44:   seg = 8'h3D; // D
      8'h45:   seg = 8'h4F; // E
      8'h46:   seg = 8'h47; // F
      8'h47:   seg = 8'h5E; // G
      8'h48:   seg = 8'h37; // H
      8'h68:   seg = 8'h17; // h
      8'h49:   seg = 8'h06; // I
      8'h4A:   seg = 8'h38; // J
      8'h4C:   seg = 8'h0E; // L
      8'h4E:   seg = 8'h76; // N
      8'h6E:   seg = 8'h15; // n
      8'h6F:   seg = 8'h1D; // o
      8'h50:   seg = 8'h67; // P
      8'h72:   seg = 8'h05; // r
      8'h74:   seg = 8'h0F; // t
      8'h55:   seg = 8'h3E; // U
      8'h75:   seg = 8'h1C; // u
      8'h79:   seg = 8'h3B; // y
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage

/* hdl/vfd_digit_scan_frame_builder.sv */
// Top level: digit store, scan pointer and driver frame generation for the VFD tube.
// Path: a scan item's frame reaches the out_ ports through the input register, then the
// result register; write items produce nothing.
// Throughput: one item per cycle, busy is never raised; the receiver cannot stall.
// Reset (rst_n low, synchronous) blanks all digits, clears all dots, zeroes the scan
// pointer and drops any item in flight.
module vfd_digit_scan_frame_builder #(
  parameter int unsigned DIGIT_COUNT = vfd_pkg::DigitCountDefault,
  parameter int unsigned FRAME_BITS  = vfd_pkg::FrameBitsDefault
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_opcode,
  input  logic [vfd_pkg::PosW-1:0]   in_digit_position,
  input  logic [vfd_pkg::CharW-1:0]  in_char_code,
  input  logic                       in_dot_on,
  output logic                       out_valid,
  output logic [vfd_pkg::FrameW-1:0] out_frame_word,
  output logic [vfd_pkg::PosW-1:0]   out_scanned_digit,
  output logic                       out_pass_last
);
  import vfd_pkg::*;

  localparam logic [63:0] FrameMaskWide = (64'(1) << FRAME_BITS) - 64'(1);
  localparam logic [FrameW-1:0] FrameMask = FrameMaskWide[FrameW-1:0];
  localparam vfd_pos_t LastDigit = PosW'(DIGIT_COUNT - 1);

  // Input register.
  logic      item_vld_r;
  vfd_op_t   op_r;
  vfd_pos_t  pos_r;
  vfd_char_t char_r;
  logic      dot_r;

  // Display state.
  vfd_char_t char_store_r [MaxDigits];
  logic      dot_store_r  [MaxDigits];
  vfd_pos_t  scan_ptr_r, scan_ptr_nxt;

  // Result register.
  logic              out_valid_r, out_valid_nxt;
  logic [FrameW-1:0] frame_r, frame_nxt;
  vfd_pos_t          digit_r;
  logic              last_r, last_nxt;

  logic                 do_write, do_scan;
  vfd_pos_t             scan_d;
  logic [7:0]           seg;
  logic [FrameIdxW-1:0] grid_bit;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else begin
      item_vld_r <= start;
    end
    op_r   <= vfd_op_t'(in_opcode);
    pos_r  <= in_digit_position;
    char_r <= in_char_code;
    dot_r  <= in_dot_on;
  end

  assign do_write = item_vld_r && (op_r == OP_WRITE) && (32'(pos_r) < DIGIT_COUNT);
  assign do_scan  = item_vld_r && (op_r == OP_SCAN);

  always_comb begin
    // An out-of-range pointer falls back to the first digit.
    scan_d   = (32'(scan_ptr_r) < DIGIT_COUNT) ? scan_ptr_r : '0;
    seg      = seg_lookup(char_store_r[scan_d]);
    grid_bit = FrameIdxW'(GridTopBit) - FrameIdxW'(scan_d);

    frame_nxt    = '0;
    frame_nxt[0] = seg[6];
    frame_nxt[1] = seg[5];
    frame_nxt[2] = seg[4];
    frame_nxt[3] = seg[3];
    frame_nxt[4] = seg[2];
    frame_nxt[5] = seg[1];
    frame_nxt[6] = seg[0];
    frame_nxt[DotBit] = dot_store_r[scan_d];
    frame_nxt[grid_bit] = 1'b1;
    frame_nxt = frame_nxt & FrameMask;

    last_nxt      = (scan_d == LastDigit);
    out_valid_nxt = do_scan;
    scan_ptr_nxt  = scan_ptr_r;
    if (do_scan) begin
      scan_ptr_nxt = last_nxt ? '0 : scan_d + PosW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_ptr_r  <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MaxDigits; i++) begin
        char_store_r[i] <= '0;
        dot_store_r[i]  <= 1'b0;
      end
    end else begin
      scan_ptr_r  <= scan_ptr_nxt;
      out_valid_r <= out_valid_nxt;
      if (do_write) begin
        char_store_r[pos_r] <= char_r;
        dot_store_r[pos_r]  <= dot_r;
      end
    end
    if (do_scan) begin
      frame_r <= frame_nxt;
      digit_r <= scan_d;
      last_r  <= last_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_frame_word    = frame_r;
  assign out_scanned_digit = digit_r;
  assign out_pass_last     = last_r;

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the VFD digit scan frame builder: random bursts of writes and scans.
module tb;
  import vfd_pkg::*;

  typedef struct packed {
    logic      drain_first;
    vfd_op_t   op;
    vfd_pos_t  pos;
    vfd_char_t ch;
    logic      dot;
  } tube_cmd_t;

  typedef struct packed {
    logic [FrameW-1:0] frame;
    vfd_pos_t          digit;
    logic              last;
  } tube_frame_t;

  localparam int unsigned ItemTarget = 1150;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  vfd_op_t           in_opcode = OP_WRITE;
  vfd_pos_t          in_digit_position = '0;
  vfd_char_t         in_char_code = '0;
  logic              in_dot_on = 1'b0;
  logic              out_valid;
  logic [FrameW-1:0] out_frame_word;
  vfd_pos_t          out_scanned_digit;
  logic              out_pass_last;

  tube_cmd_t   display_cmds[$];
  tube_frame_t frames_due[$];

  // Predicted display contents and scan position.
  vfd_char_t   glyph_mem[MaxDigits];
  logic        dot_mem[MaxDigits];
  vfd_pos_t    scan_ptr;

  int unsigned issued_count = 0;
  int unsigned taken_count = 0;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  int unsigned item_total = 0;
  int unsigned errors = 0;

  string glyph_text = "0123456789ABcCDEFGHhIJLNnoPrtUuy";

  vfd_digit_scan_frame_builder dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_opcode         (in_opcode),
    .in_digit_position (in_digit_position),
    .in_char_code      (in_char_code),
    .in_dot_on         (in_dot_on),
    .out_valid         (out_valid),
    .out_frame_word    (out_frame_word),
    .out_scanned_digit (out_scanned_digit),
    .out_pass_last     (out_pass_last)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Segment pattern per character as {high nibble, low nibble}.
  function automatic logic [7:0] glyph_segments(input vfd_char_t c);
    logic [7:0] seg;
    unique case (c)
      "0": seg = 8'h7E;
      "1": seg = 8'h30;
      "2": seg = 8'h6D;
      "3": seg = 8'h79;
      "4": seg = 8'h33;
      "5": seg = 8'h5B;
      "6": seg = 8'h5F;
      "7": seg = 8'h70;
      "8": seg = 8'h7F;
      "9": seg = 8'h7B;
      "A": seg = 8'h77;
      "B": seg = 8'h1F;
      "c", "C": seg = 8'h4E;
      "D": seg = 8'h3D;
      "E": seg = 8'h4F;
      "F": seg = 8'h47;
      "G": seg = 8'h5E;
      "H": seg = 8'h37;
      "h": seg = 8'h17;
      "I": seg = 8'h06;
      "J": seg = 8'h38;
      "L": seg = 8'h0E;
      "N": seg = 8'h76;
      "n": seg = 8'h15;
      "o": seg = 8'h1D;
      "P": seg = 8'h67;
      "r": seg = 8'h05;
      "t": seg = 8'h0F;
      "U": seg = 8'h3E;
      "u": seg = 8'h1C;
      "y": seg = 8'h3B;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

  function automatic tube_frame_t tube_frame(input vfd_pos_t d);
    tube_frame_t          r;
    logic [7:0]           seg;
    logic [FrameIdxW-1:0] grid_bit;
    seg = glyph_segments(glyph_mem[d]);
    grid_bit = FrameIdxW'(GridTopBit) - FrameIdxW'(d);
    r.frame = '0;
    // The high nibble lands reversed in bits 0..2, the low nibble reversed in bits 3..6.
    r.frame[0] = seg[6];
    r.frame[1] = seg[5];
    r.frame[2] = seg[4];
    r.frame[3] = seg[3];
    r.frame[4] = seg[2];
    r.frame[5] = seg[1];
    r.frame[6] = seg[0];
    r.frame[DotBit] = dot_mem[d];
    r.frame[grid_bit] = 1'b1;
    r.digit = d;
    r.last = (d == vfd_pos_t'(DigitCountDefault - 1));
    return r;
  endfunction

  function automatic void queue_cmd(input vfd_op_t op, input vfd_pos_t pos,
                                    input vfd_char_t ch, input logic dot,
                                    input logic drain);
    tube_cmd_t c;
    c.drain_first = drain;
    c.op = op;
    c.pos = pos;
    c.ch = ch;
    c.dot = dot;
    display_cmds.push_back(c);
    item_total++;
  endfunction

  function automatic vfd_char_t any_glyph();
    return vfd_char_t'(glyph_text[$urandom_range(0, glyph_text.len() - 1)]);
  endfunction

  always @(negedge clk) begin : drive_blk
    tube_cmd_t c;
    logic      go;
    go = 1'b0;
    c = '0;
    if (rst_n && issued_count == taken_count) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (display_cmds.size() > 0 &&
                   (!display_cmds[0].drain_first || frames_due.size() == 0)) begin
        c = display_cmds.pop_front();
        go = 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
    if (go) begin
      start <= 1'b1;
      in_opcode <= c.op;
      in_digit_position <= c.pos;
      in_char_code <= c.ch;
      in_dot_on <= c.dot;
      issued_count <= issued_count + 1;
    end else if (issued_count == taken_count) begin
      // Idle cycles carry junk on the payload ports.
      start <= 1'b0;
      in_opcode <= vfd_op_t'($urandom_range(0, 1));
      in_digit_position <= vfd_pos_t'($urandom_range(0, 7));
      in_char_code <= vfd_char_t'($urandom_range(0, 255));
      in_dot_on <= 1'($urandom_range(0, 1));
    end
  end

  always @(posedge clk) begin : watch_blk
    tube_frame_t want;
    if (!rst_n) begin
      for (int i = 0; i < MaxDigits; i++) begin
        glyph_mem[i] = '0;
        dot_mem[i] = 1'b0;
      end
      scan_ptr = '0;
    end else begin
      if (out_valid) begin
        if (frames_due.size() == 0) begin
          errors++;
          $display("%0t unexpected frame: expected none actual frame %h digit %0d last %0d",
                   $time, out_frame_word, out_scanned_digit, out_pass_last);
        end else begin
          want = frames_due.pop_front();
          if (out_frame_word !== want.frame) begin
            errors++;
            $display("%0t frame_word mismatch: expected %h actual %h",
                     $time, want.frame, out_frame_word);
          end
          if (out_scanned_digit !== want.digit) begin
            errors++;
            $display("%0t scanned_digit mismatch: expected %0d actual %0d",
                     $time, want.digit, out_scanned_digit);
          end
          if (out_pass_last !== want.last) begin
            errors++;
            $display("%0t pass_last mismatch: expected %0d actual %0d",
                     $time, want.last, out_pass_last);
          end
        end
      end
      if (start && !busy) begin
        taken_count <= taken_count + 1;
        if (in_opcode == OP_WRITE) begin
          if (int'(in_digit_position) < DigitCountDefault) begin
            glyph_mem[in_digit_position] = in_char_code;
            dot_mem[in_digit_position] = in_dot_on;
          end
        end else begin
          frames_due.push_back(tube_frame(scan_ptr));
          scan_ptr = (scan_ptr == vfd_pos_t'(DigitCountDefault - 1)) ? '0
                                                                      : scan_ptr + vfd_pos_t'(1);
        end
      end
    end
  end

  initial begin
    #2ms;
    $display("vfd_digit_scan_frame_builder verification failed");
    $finish;
  end

  initial begin : main_blk
    int unsigned n;
    logic        drain;
    // A full pass over blank digits, then one more scan to see the pointer wrap.
    for (int i = 0; i < 9; i++) queue_cmd(OP_SCAN, '0, '0, 1'b0, 1'b0);
    queue_cmd(OP_WRITE, 3'd0, "c", 1'b1, 1'b0);
    queue_cmd(OP_WRITE, 3'd7, 8'hFF, 1'b1, 1'b0);
    queue_cmd(OP_WRITE, 3'd3, "C", 1'b0, 1'b0);
    queue_cmd(OP_WRITE, 3'd5, "8", 1'b1, 1'b0);
    queue_cmd(OP_WRITE, 3'd6, 8'h00, 1'b1, 1'b0);
    queue_cmd(OP_SCAN, 3'd7, 8'hFF, 1'b1, 1'b1);
    for (int i = 0; i < 7; i++) queue_cmd(OP_SCAN, '0, '0, 1'b0, 1'b0);

    while (item_total < ItemTarget) begin
      if ($urandom_range(0, 9) < 7) begin
        // A message: a few digit writes followed by a run of scans.
        drain = ($urandom_range(0, 19) == 0);
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
          queue_cmd(OP_WRITE, vfd_pos_t'($urandom_range(0, 7)),
                    ($urandom_range(0, 7) == 0) ? vfd_char_t'($urandom_range(0, 255))
                                                : any_glyph(),
                    1'($urandom_range(0, 1)), drain && i == 0);
        end
        n = $urandom_range(1, 16);
        for (int i = 0; i < n; i++) begin
          queue_cmd(OP_SCAN, vfd_pos_t'($urandom_range(0, 7)),
                    vfd_char_t'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
        end
      end else begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
          queue_cmd(vfd_op_t'($urandom_range(0, 1)), vfd_pos_t'($urandom_range(0, 7)),
                    vfd_char_t'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
        end
      end
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (display_cmds.size() != 0 || issued_count != taken_count) @(posedge clk);
    while (frames_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (errors == 0) begin
      $display("vfd_digit_scan_frame_builder verification clean");
    end else begin
      $display("vfd_digit_scan_frame_builder verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/vfd_pkg.sv
hdl/vfd_digit_scan_frame_builder.sv
sim/tb.sv
